// File: hdl/sc_pkg.sv
// Shared types, constants and helper functions for the shuffled Salsa20 core.
// Used by the round step stages, the finishing stage and the top level.
package sc_pkg;

   localparam int WORDS     = 16;
   localparam int FIELDS    = 8;
   localparam int MAX_PAIRS = 16;
   localparam int NUM_STEPS = MAX_PAIRS * 8;
   localparam int PAIR_W    = 5;
   localparam int COUNT_W   = 5;

   localparam logic [COUNT_W-1:0] ROUND_COUNT_RESET = 5'd8;

   typedef logic [31:0] word_type;
   typedef word_type [WORDS-1:0] block_type;

   typedef struct packed {
      logic              valid;
      logic [PAIR_W-1:0] pairs;
      block_type         state;
      block_type         orig;
   } stage_type;

   // Core position of shuffled word i.
   function automatic logic [3:0] shuffle_pos(input int i);
      shuffle_pos = 4'(i * 5);
   endfunction

   // Position of element k of quarter q in a column round (row = 0) or a row round.
   function automatic logic [3:0] quarter_pos(input int row, input int q, input int k);
      if (row != 0) begin
         quarter_pos = 4'(4 * q + ((q + k) & 3));
      end else begin
         quarter_pos = 4'(5 * q + 4 * k);
      end
   endfunction

   function automatic int step_rot(input int step);
      case (step)
         0:       step_rot = 7;
         1:       step_rot = 9;
         2:       step_rot = 13;
         default: step_rot = 18;
      endcase
   endfunction

   function automatic word_type rotl(input word_type v, input int amt);
      rotl = (v << amt) | (v >> (32 - amt));
   endfunction

endpackage

// File: hdl/sc_step.sv
// One pipeline stage: one add-rotate-xor step applied to all four quarters of a round.
// Depends on sc_pkg. The step is skipped when the request needs fewer double rounds.
module sc_step
   import sc_pkg::*;
#(
   parameter int DOUBLE_IDX = 0,
   parameter int ROW        = 0,
   parameter int STEP       = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type up,
   output stage_type down
);

   localparam int ROT = step_rot(STEP);

   stage_type down_ff;
   stage_type down_in;

   always_comb begin
      down_in = up;
      if (up.pairs > PAIR_W'(DOUBLE_IDX)) begin
         for (int q = 0; q < 4; q++) begin
            down_in.state[quarter_pos(ROW, q, (STEP + 1) & 3)] =
               up.state[quarter_pos(ROW, q, (STEP + 1) & 3)] ^
               rotl(up.state[quarter_pos(ROW, q, STEP)] +
                    up.state[quarter_pos(ROW, q, (STEP + 3) & 3)], ROT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff.valid <= 1'b0;
      end else if (advance) begin
         down_ff <= down_in;
      end
   end

   assign down = down_ff;

endmodule

// File: hdl/sc_finish.sv
// Final stage: adds the input back to the shuffled core state into the output register.
// Depends on sc_pkg.
module sc_finish
   import sc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type up,
   output logic      valid,
   output block_type result
);

   logic      valid_ff;
   block_type result_ff;
   block_type result_in;

   always_comb begin
      for (int i = 0; i < WORDS; i++) begin
         result_in[i] = up.orig[i] + up.state[shuffle_pos(i)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign valid  = valid_ff;
   assign result = result_ff;

endmodule

// File: hdl/salsa20_core_shuffled_core.sv
// Shuffled-order Salsa20 core, fully pipelined: one request per cycle while not stalled.
// An entry register, 128 step stages (one add-rotate-xor step of every quarter each,
// 16 double rounds at most) and the output register that adds the input back in.
// The whole pipeline stalls together while a result waits on rsp_ready.
// Synchronous reset empties the pipeline and sets round_count to 8.
module salsa20_core_shuffled_core
   import sc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [4:0]   csr_round_count,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [63:0]  req_words_0_1,
   input  logic [63:0]  req_words_2_3,
   input  logic [63:0]  req_words_4_5,
   input  logic [63:0]  req_words_6_7,
   input  logic [63:0]  req_words_8_9,
   input  logic [63:0]  req_words_10_11,
   input  logic [63:0]  req_words_12_13,
   input  logic [63:0]  req_words_14_15,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [63:0]  rsp_out_0_1,
   output logic [63:0]  rsp_out_2_3,
   output logic [63:0]  rsp_out_4_5,
   output logic [63:0]  rsp_out_6_7,
   output logic [63:0]  rsp_out_8_9,
   output logic [63:0]  rsp_out_10_11,
   output logic [63:0]  rsp_out_12_13,
   output logic [63:0]  rsp_out_14_15
);

   logic [COUNT_W-1:0] round_count_ff;
   logic               advance;
   block_type          words;
   block_type          result;
   stage_type          entry_ff;
   stage_type          entry_in;
   stage_type          chain [NUM_STEPS+1];
   logic [COUNT_W:0]   rounds_up;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         round_count_ff <= ROUND_COUNT_RESET;
      end else if (csr_valid) begin
         round_count_ff <= csr_round_count;
      end
   end

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign words[1:0]   = req_words_0_1;
   assign words[3:2]   = req_words_2_3;
   assign words[5:4]   = req_words_4_5;
   assign words[7:6]   = req_words_6_7;
   assign words[9:8]   = req_words_8_9;
   assign words[11:10] = req_words_10_11;
   assign words[13:12] = req_words_12_13;
   assign words[15:14] = req_words_14_15;

   assign rounds_up = {1'b0, round_count_ff} + 6'd1;

   always_comb begin
      entry_in.valid = req_valid;
      entry_in.pairs = rounds_up[COUNT_W:1];
      entry_in.orig  = words;
      entry_in.state = words;
      for (int i = 0; i < WORDS; i++) begin
         entry_in.state[shuffle_pos(i)] = words[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign chain[0] = entry_ff;

   for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
      sc_step #(
         .DOUBLE_IDX (g / 8),
         .ROW        ((g / 4) % 2),
         .STEP       (g % 4)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up      (chain[g]),
         .down    (chain[g+1])
      );
   end

   sc_finish u_finish (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .up      (chain[NUM_STEPS]),
      .valid   (rsp_valid),
      .result  (result)
   );

   assign rsp_out_0_1   = result[1:0];
   assign rsp_out_2_3   = result[3:2];
   assign rsp_out_4_5   = result[5:4];
   assign rsp_out_6_7   = result[7:6];
   assign rsp_out_8_9   = result[9:8];
   assign rsp_out_10_11 = result[11:10];
   assign rsp_out_12_13 = result[13:12];
   assign rsp_out_14_15 = result[15:14];

endmodule

// File: dv/tb_salsa20_core_shuffled_core.sv
// Self-checking testbench for the shuffled-order Salsa20 core.
// It predicts responses (own Salsa20 model or directed), drives the request and
// response channels with random bursts and stalls, and needs only the RTL.
module tb_salsa20_core_shuffled_core;

   typedef logic [7:0][63:0] field_vec_type;

   typedef struct packed {
      logic [4:0]    rounds;
      field_vec_type din;
      logic          has_exp;
      field_vec_type dexp;
   } stim_row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_type;

   localparam logic [4:0] RESET_ROUNDS   = 5'd8;
   localparam int         DIRECTED_ROWS  = 23;
   localparam int         RANDOM_PHASES  = 8;
   localparam int         PHASE_REQUESTS = 220;
   localparam int         PIPE_LATENCY   = 130;
   localparam int         REPORT_CAP     = 100;

   localparam logic [0:31][3:0] QUARTER_POS = {
      4'h0, 4'h4, 4'h8, 4'hc,  4'h5, 4'h9, 4'hd, 4'h1,
      4'ha, 4'he, 4'h2, 4'h6,  4'hf, 4'h3, 4'h7, 4'hb,
      4'h0, 4'h1, 4'h2, 4'h3,  4'h5, 4'h6, 4'h7, 4'h4,
      4'ha, 4'hb, 4'h8, 4'h9,  4'hf, 4'hc, 4'hd, 4'he
   };

   localparam field_vec_type COUNT_PATTERN = {
      64'h0000000f_0000000e, 64'h0000000d_0000000c,
      64'h0000000b_0000000a, 64'h00000009_00000008,
      64'h00000007_00000006, 64'h00000005_00000004,
      64'h00000003_00000002, 64'h00000001_00000000
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [4:0]    csr_round_count = '0;
   logic          req_valid = 1'b0;
   logic          req_ready;
   field_vec_type req_data = '0;
   logic          req_has_exp = 1'b0;
   field_vec_type req_exp = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   field_vec_type rsp_data;

   field_vec_type hash_q[$];
   logic [4:0]    model_rounds = RESET_ROUNDS;
   logic [4:0]    rounds_now = RESET_ROUNDS;
   int            n_requests = 0;
   int            n_responses = 0;
   int            n_settings = 0;
   int            n_errors = 0;
   int            burst_left = 0;

   rx_mode_type   rx_mode = RX_OPEN;
   int            rx_mode_left = 0;
   int            rx_hold_left = 0;
   logic [2:0]    rx_phase = '0;

   salsa20_core_shuffled_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_round_count (csr_round_count),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_words_0_1   (req_data[0]),
      .req_words_2_3   (req_data[1]),
      .req_words_4_5   (req_data[2]),
      .req_words_6_7   (req_data[3]),
      .req_words_8_9   (req_data[4]),
      .req_words_10_11 (req_data[5]),
      .req_words_12_13 (req_data[6]),
      .req_words_14_15 (req_data[7]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_0_1     (rsp_data[0]),
      .rsp_out_2_3     (rsp_data[1]),
      .rsp_out_4_5     (rsp_data[2]),
      .rsp_out_6_7     (rsp_data[3]),
      .rsp_out_8_9     (rsp_data[4]),
      .rsp_out_10_11   (rsp_data[5]),
      .rsp_out_12_13   (rsp_data[6]),
      .rsp_out_14_15   (rsp_data[7])
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] rot_left(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic field_vec_type salsa_hash(input field_vec_type din,
                                                input logic [4:0] rounds);
      logic [31:0]   w [0:15];
      logic [31:0]   x [0:15];
      logic [31:0]   a, b, c, d;
      field_vec_type dout;
      int            i, p, q, pairs;
      for (i = 0; i < 16; i++) begin
         w[i] = din[i / 2][32 * (i % 2) +: 32];
         x[(i * 5) % 16] = w[i];
      end
      pairs = (int'(rounds) + 1) / 2;
      for (p = 0; p < pairs; p++) begin
         for (q = 0; q < 8; q++) begin
            a = x[QUARTER_POS[4 * q]];
            b = x[QUARTER_POS[4 * q + 1]];
            c = x[QUARTER_POS[4 * q + 2]];
            d = x[QUARTER_POS[4 * q + 3]];
            b = b ^ rot_left(a + d, 7);
            c = c ^ rot_left(b + a, 9);
            d = d ^ rot_left(c + b, 13);
            a = a ^ rot_left(d + c, 18);
            x[QUARTER_POS[4 * q]]     = a;
            x[QUARTER_POS[4 * q + 1]] = b;
            x[QUARTER_POS[4 * q + 2]] = c;
            x[QUARTER_POS[4 * q + 3]] = d;
         end
      end
      for (i = 0; i < 16; i++) begin
         dout[i / 2][32 * (i % 2) +: 32] = w[i] + x[(i * 5) % 16];
      end
      return dout;
   endfunction

   function automatic stim_row_type directed_row(input int n);
      stim_row_type r;
      r = '0;
      r.rounds = RESET_ROUNDS;
      case (n)
         0: r.has_exp = 1'b1;
         1: r.din = {8{64'hffffffff_ffffffff}};
         2: r.din = {8{64'h80000000_00000001}};
         3: r.din = COUNT_PATTERN;
         4: begin
            r.rounds  = 5'd0;
            r.has_exp = 1'b1;
         end
         5: begin
            r.rounds  = 5'd0;
            r.din     = {8{64'hffffffff_ffffffff}};
            r.has_exp = 1'b1;
            r.dexp    = {8{64'hfffffffe_fffffffe}};
         end
         6: begin
            r.rounds  = 5'd0;
            r.din     = {8{64'h80000000_80000000}};
            r.has_exp = 1'b1;
         end
         7: begin
            r.rounds  = 5'd0;
            r.din     = {8{64'h40000001_00000003}};
            r.has_exp = 1'b1;
            r.dexp    = {8{64'h80000002_00000006}};
         end
         8: begin
            r.rounds = 5'd0;
            r.din    = COUNT_PATTERN;
         end
         9: begin
            r.rounds = 5'd1;
            r.din    = COUNT_PATTERN;
         end
         10: begin
            r.rounds = 5'd1;
            r.din    = {8{64'hffffffff_ffffffff}};
         end
         11: begin
            r.rounds  = 5'd1;
            r.has_exp = 1'b1;
         end
         12: begin
            r.rounds = 5'd2;
            r.din    = COUNT_PATTERN;
         end
         13: begin
            r.rounds = 5'd2;
            r.din    = {8{64'hffffffff_ffffffff}};
         end
         14: begin
            r.rounds  = 5'd20;
            r.has_exp = 1'b1;
         end
         15: begin
            r.rounds = 5'd20;
            r.din    = {8{64'hffffffff_ffffffff}};
         end
         16: begin
            r.rounds = 5'd20;
            r.din    = COUNT_PATTERN;
         end
         17: begin
            r.rounds = 5'd21;
            r.din    = COUNT_PATTERN;
         end
         18: begin
            r.rounds = 5'd31;
            r.din    = {8{64'hffffffff_ffffffff}};
         end
         19: begin
            r.rounds = 5'd31;
            r.din    = COUNT_PATTERN;
         end
         20: begin
            r.rounds  = 5'd31;
            r.has_exp = 1'b1;
         end
         21: begin
            r.rounds = 5'd30;
            r.din    = COUNT_PATTERN;
         end
         22: r.din[0] = 64'h1;
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'hffffffff;
         2: return 32'h80000000;
         3: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic field_vec_type random_block();
      field_vec_type v;
      logic          corner;
      int            k;
      corner = ($urandom_range(0, 7) == 0);
      for (k = 0; k < 8; k++) begin
         if (corner) begin
            v[k] = {pick_word(), pick_word()};
         end else begin
            v[k] = {$urandom, $urandom};
         end
      end
      return v;
   endfunction

   task automatic send_request(input field_vec_type din, input logic has_exp,
                               input field_vec_type dexp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_data    <= din;
      req_has_exp <= has_exp;
      req_exp     <= dexp;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (hash_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_rounds(input logic [4:0] value);
      drain();
      csr_valid       <= 1'b1;
      csr_round_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      rounds_now = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_phase <= rx_phase + 3'd1;
         if (rx_mode_left == 0) begin
            rx_mode      <= rx_mode_type'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(50, 400);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         case (rx_mode)
            RX_OPEN:     rsp_ready <= 1'b1;
            RX_RANDOM:   rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_ready <= (rx_phase != 3'd5) && (rx_phase != 3'd6);
            RX_LONG: begin
               if (rx_hold_left == 0) begin
                  rsp_ready    <= !rsp_ready;
                  rx_hold_left <= $urandom_range(1, 20);
               end else begin
                  rx_hold_left <= rx_hold_left - 1;
               end
            end
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      field_vec_type want;
      int            k;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            model_rounds = csr_round_count;
            n_settings++;
         end
         if (req_valid && req_ready) begin
            hash_q.push_back(req_has_exp ? req_exp : salsa_hash(req_data, model_rounds));
            n_requests++;
         end
         if (rsp_valid && rsp_ready) begin
            if (hash_q.size() == 0) begin
               n_errors++;
               if (n_errors <= REPORT_CAP) begin
                  $display("%0t: response with nothing outstanding, actual %h", $time, rsp_data);
               end
            end else begin
               want = hash_q.pop_front();
               n_responses++;
               for (k = 0; k < 8; k++) begin
                  if (rsp_data[k] !== want[k]) begin
                     n_errors++;
                     if (n_errors <= REPORT_CAP) begin
                        $display("%0t: field %0d expected %h actual %h",
                                 $time, k, want[k], rsp_data[k]);
                     end
                  end
               end
            end
         end
      end
   end

   initial begin
      #1_600_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      stim_row_type row;
      logic [4:0]   phase_rounds;
      int           n, ph;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         row = directed_row(n);
         if (row.rounds != rounds_now) begin
            set_rounds(row.rounds);
         end
         send_request(row.din, row.has_exp, row.dexp);
      end

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: phase_rounds = 5'd0;
            1: phase_rounds = 5'd31;
            2: phase_rounds = 5'd20;
            3: phase_rounds = 5'd1;
            4: phase_rounds = 5'($urandom_range(0, 31));
            5: phase_rounds = RESET_ROUNDS;
            6: phase_rounds = 5'($urandom_range(0, 15) * 2 + 1);
            default: phase_rounds = 5'($urandom_range(0, 31));
         endcase
         set_rounds(phase_rounds);
         for (n = 0; n < PHASE_REQUESTS; n++) begin
            send_request(random_block(), 1'b0, '0);
         end
      end

      drain();
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      $display("Checked %0d responses to %0d requests across %0d round-count writes.",
               n_responses, n_requests, n_settings);
      $display("Round counts covered zero, odd, even, twenty, thirty-one and random values.");
      if (n_errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
